// ===== src/nert_pkg.sv =====
`default_nettype none

package nert_pkg;

    localparam int COORD_BITS   = 10;
    localparam int PIN_BITS     = 16;
    localparam int CFG_BITS     = 11;
    localparam int CFG_IDX_BITS = 2;

    // One past the largest coordinate; a grid size above this saturates.
    localparam longint unsigned GRID_LIMIT = 64'd1 << COORD_BITS;

    typedef logic [COORD_BITS-1:0]   t_coord;
    typedef logic [PIN_BITS-1:0]     t_pin_id;
    typedef logic [CFG_BITS-1:0]     t_size;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_NUM_ROWS    = CFG_IDX_BITS'(0),
        REG_NUM_COLUMNS = CFG_IDX_BITS'(1)
    } t_cfg_reg;

    localparam t_size SIZE_RESET = CFG_BITS'(1024);

    typedef struct packed {
        t_coord  row;
        t_coord  column;
        t_pin_id pin_id;
        logic    last_pin;
    } t_pin_item;

    // Extremes, runner-ups and extreme holders of one axis.
    typedef struct packed {
        t_coord  min;
        t_coord  next_min;
        t_coord  max;
        t_coord  next_max;
        t_pin_id low_pin;
        t_pin_id high_pin;
    } t_axis_view;

    typedef struct packed {
        t_pin_id left_pin;
        t_pin_id right_pin;
        t_pin_id top_pin;
        t_pin_id bottom_pin;
        t_coord  left_slack;
        t_coord  right_slack;
        t_coord  up_slack;
        t_coord  down_slack;
    } t_result;

    // Starting value of the low-side bounds: size minus one, or all ones when
    // the size is zero or larger than the coordinate range.
    function automatic t_coord low_default(t_size size);
        t_coord value;
        if (size == '0 || 64'(size) > GRID_LIMIT) begin
            value = '1;
        end else begin
            value = COORD_BITS'(size - CFG_BITS'(1));
        end
        return value;
    endfunction

endpackage

`default_nettype wire

// ===== src/nert_pin_if.sv =====
`default_nettype none

interface nert_pin_if;
    import nert_pkg::*;

    logic    valid;
    logic    ready;
    t_coord  row;
    t_coord  column;
    t_pin_id pin_id;
    logic    last_pin;

    modport source (output valid, output row, output column, output pin_id,
                    output last_pin, input ready);
    modport sink   (input valid, input row, input column, input pin_id,
                    input last_pin, output ready);
endinterface

`default_nettype wire

// ===== src/nert_res_if.sv =====
`default_nettype none

interface nert_res_if;
    import nert_pkg::*;

    logic    valid;
    logic    ready;
    t_pin_id left_pin;
    t_pin_id right_pin;
    t_pin_id top_pin;
    t_pin_id bottom_pin;
    t_coord  left_slack;
    t_coord  right_slack;
    t_coord  up_slack;
    t_coord  down_slack;

    modport source (output valid, output left_pin, output right_pin, output top_pin,
                    output bottom_pin, output left_slack, output right_slack,
                    output up_slack, output down_slack, input ready);
    modport sink   (input valid, input left_pin, input right_pin, input top_pin,
                    input bottom_pin, input left_slack, input right_slack,
                    input up_slack, input down_slack, output ready);
endinterface

`default_nettype wire

// ===== src/nert_cfg_if.sv =====
`default_nettype none

interface nert_cfg_if;
    import nert_pkg::*;

    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_size    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/nert_pin_reg.sv =====
`default_nettype none

module nert_pin_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    nert_pin_if.sink            i_pin,
    input  logic                i_adv,
    output logic                o_valid,
    output nert_pkg::t_pin_item o_item
);
    import nert_pkg::*;

    logic      r_valid;
    t_pin_item r_item;

    // The register takes a new beat whenever it is empty or drains this cycle.
    assign i_pin.ready = !r_valid || i_adv;
    assign o_valid     = r_valid;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pin.ready) begin
            r_valid <= i_pin.valid;
        end
        if (i_pin.valid && i_pin.ready) begin
            r_item <= '{row: i_pin.row, column: i_pin.column,
                        pin_id: i_pin.pin_id, last_pin: i_pin.last_pin};
        end
    end

endmodule

`default_nettype wire

// ===== src/nert_axis.sv =====
`default_nettype none

module nert_axis (
    input  logic                 i_clk,
    input  logic                 i_step,
    input  logic                 i_open,
    input  nert_pkg::t_coord     i_low_default,
    input  nert_pkg::t_coord     i_coord,
    input  nert_pkg::t_pin_id    i_pin_id,
    output nert_pkg::t_axis_view o_view
);
    import nert_pkg::*;

    t_axis_view r_view;
    t_axis_view base;
    t_axis_view n_view;

    // The first pin of a net starts from the grid defaults and owns every slot.
    always_comb begin
        if (i_open) begin
            base = '{min: i_low_default, next_min: i_low_default,
                     max: '0, next_max: '0,
                     low_pin: i_pin_id, high_pin: i_pin_id};
        end else begin
            base = r_view;
        end

        n_view = base;
        if (i_coord < base.min) begin
            n_view.next_min = base.min;
            n_view.min      = i_coord;
            n_view.low_pin  = i_pin_id;
        end else if (i_coord < base.next_min) begin
            n_view.next_min = i_coord;
        end

        if (i_coord > base.max) begin
            n_view.next_max = base.max;
            n_view.max      = i_coord;
            n_view.high_pin = i_pin_id;
        end else if (i_coord > base.next_max) begin
            n_view.next_max = i_coord;
        end
    end

    assign o_view = n_view;

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_view <= n_view;
        end
    end

endmodule

`default_nettype wire

// ===== src/net_extreme_and_runner_up_tracker.sv =====
`default_nettype none

// Net extreme and runner-up tracker. Pins of a net arrive one beat at a time
// on i_pin (row, column, pin number, last flag); for both axes the block keeps
// the extreme coordinates, the runner-up coordinates and the pin numbers that
// hold the extremes. The beat that carries last_pin produces one result beat on
// o_res with the left, right, top and bottom pin numbers and the four slacks,
// each the gap between runner-up and extreme; pins without last_pin produce
// nothing. A new net starts from defaults derived from the grid size: the low
// bounds start at size minus one (all ones for a size of zero or one beyond the
// coordinate range) and the high bounds at zero, so a single-pin net reports
// its distance to those bounds. The first pin of a net owns all four extreme
// slots until another pin beats it. Throughput is one pin per clock: each pin
// needs only a compare against the registered extremes of its axis. A pin is
// held in an input register, and when the last pin of a net moves on from that
// register, the net's result is written into the output register that drives
// o_res. The result register frees up the same cycle it is taken, and a
// waiting result only stalls the pipeline when the next net's last pin has to
// overwrite it. Grid size is written through i_cfg (index 0 is num_rows, index
// 1 is num_columns), takes effect at the start of the next net, and should only
// be changed while no pin is in flight.
module net_extreme_and_runner_up_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nert_cfg_if.sink    i_cfg,
    nert_pin_if.sink    i_pin,
    nert_res_if.source  o_res
);
    import nert_pkg::*;

    // Grid size registers.
    t_size r_num_rows;
    t_size r_num_columns;

    // Input stage.
    logic      pin_valid;
    t_pin_item pin_item;
    logic      adv;

    // Tracking state.
    logic       r_net_open;
    t_axis_view col_view;
    t_axis_view row_view;

    // Result register.
    logic    r_res_valid;
    t_result r_res;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows    <= SIZE_RESET;
            r_num_columns <= SIZE_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_NUM_ROWS: begin
                    r_num_rows <= i_cfg.data;
                end
                REG_NUM_COLUMNS: begin
                    r_num_columns <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    nert_pin_reg u_pin_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pin   (i_pin),
        .i_adv   (adv),
        .o_valid (pin_valid),
        .o_item  (pin_item)
    );

    // A registered pin moves on every cycle unless it closes a net and the
    // result register still holds a result that is not being taken.
    assign adv = pin_valid && (!pin_item.last_pin || !r_res_valid || o_res.ready);

    nert_axis u_col_axis (
        .i_clk         (i_clk),
        .i_step        (adv),
        .i_open        (!r_net_open),
        .i_low_default (low_default(r_num_columns)),
        .i_coord       (pin_item.column),
        .i_pin_id      (pin_item.pin_id),
        .o_view        (col_view)
    );

    nert_axis u_row_axis (
        .i_clk         (i_clk),
        .i_step        (adv),
        .i_open        (!r_net_open),
        .i_low_default (low_default(r_num_rows)),
        .i_coord       (pin_item.row),
        .i_pin_id      (pin_item.pin_id),
        .o_view        (row_view)
    );

    // A net stays open from its first pin until its last pin has been tracked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net_open <= 1'b0;
        end else if (adv) begin
            r_net_open <= !pin_item.last_pin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (adv && pin_item.last_pin) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
        if (adv && pin_item.last_pin) begin
            r_res <= '{left_pin:    col_view.low_pin,
                       right_pin:   col_view.high_pin,
                       top_pin:     row_view.high_pin,
                       bottom_pin:  row_view.low_pin,
                       left_slack:  col_view.next_min - col_view.min,
                       right_slack: col_view.max - col_view.next_max,
                       up_slack:    row_view.max - row_view.next_max,
                       down_slack:  row_view.next_min - row_view.min};
        end
    end

    assign o_res.valid       = r_res_valid;
    assign o_res.left_pin    = r_res.left_pin;
    assign o_res.right_pin   = r_res.right_pin;
    assign o_res.top_pin     = r_res.top_pin;
    assign o_res.bottom_pin  = r_res.bottom_pin;
    assign o_res.left_slack  = r_res.left_slack;
    assign o_res.right_slack = r_res.right_slack;
    assign o_res.up_slack    = r_res.up_slack;
    assign o_res.down_slack  = r_res.down_slack;

    // A last pin that moves on always leaves a result behind.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && pin_item.last_pin |=> r_res_valid)
        else $error("last pin did not produce a result");

    // A pin that does not close its net leaves the net open.
    a_net_stays_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !pin_item.last_pin |=> r_net_open)
        else $error("net closed without a last pin");

    // A pending result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(adv && pin_item.last_pin && r_res_valid && !o_res.ready))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
